@@ hdl/icc_pkg.sv @@
package icc_pkg;

    localparam int LINE_COUNT_DEF     = 32;
    localparam int CONTEXT_BASE_DEF   = 32'h0020_0000;
    localparam int CONTEXT_STRIDE_DEF = 32'h0000_1000;

    localparam int REQ_W    = 2;
    localparam int OFFSET_W = 22;
    localparam int DATA_W   = 32;
    localparam int LINE_W   = 5;
    // offset compare width, two bits wider than the register offset; base + stride + 4 is truncated to it
    localparam int CMP_W    = OFFSET_W + 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_LINE  = 2'd2
    } t_req_type;

    typedef struct packed {
        t_req_type             req_type;
        logic [OFFSET_W-1:0]   reg_offset;
        logic [DATA_W-1:0]     write_data;
        logic [LINE_W-1:0]     line_number;
        logic                  line_level;
    } t_item;

endpackage

@@ hdl/icc_engine.sv @@
module icc_engine #(
    parameter int LINE_COUNT     = icc_pkg::LINE_COUNT_DEF,
    parameter int CONTEXT_BASE   = icc_pkg::CONTEXT_BASE_DEF,
    parameter int CONTEXT_STRIDE = icc_pkg::CONTEXT_STRIDE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  icc_pkg::t_item             i_item,
    output logic [icc_pkg::DATA_W-1:0] o_read_data,
    output logic                       o_ext_irq
);

    localparam int SRC_W = LINE_COUNT - 1;
    localparam int ID_W  = $clog2(LINE_COUNT);
    localparam logic [icc_pkg::CMP_W-1:0] CLAIM0 = icc_pkg::CMP_W'(CONTEXT_BASE + 4);
    localparam logic [icc_pkg::CMP_W-1:0] CLAIM1 =
        icc_pkg::CMP_W'(CONTEXT_BASE + CONTEXT_STRIDE + 4);

    logic [SRC_W-1:0] r_pending;
    logic [SRC_W-1:0] r_served;
    logic [SRC_W-1:0] n_pending;
    logic [SRC_W-1:0] n_served;
    logic [SRC_W-1:0] act;
    logic [SRC_W-1:0] lowest;
    logic [SRC_W-1:0] clr_vec;
    logic [SRC_W-1:0] line_vec;
    logic [ID_W-1:0]  low_idx;
    logic [ID_W-1:0]  claim_id;
    logic [icc_pkg::CMP_W-1:0] off_ext;
    logic             is_claim;

    assign act      = r_pending & ~r_served;
    assign lowest   = act & (~act + SRC_W'(1));
    assign off_ext  = {2'b00, i_item.reg_offset};
    assign is_claim = (off_ext == CLAIM0) || (off_ext == CLAIM1);
    assign claim_id = ID_W'(low_idx + ID_W'(1));

    // priority encoder, lowest active source wins
    always_comb begin
        low_idx = '0;
        for (int k = SRC_W - 1; k >= 0; k--) begin
            if (act[k]) begin
                low_idx = ID_W'(k);
            end
        end
    end

    // one-hot decodes of completion id and line number; out-of-range ids never match
    always_comb begin
        for (int k = 0; k < SRC_W; k++) begin
            clr_vec[k]  = (i_item.write_data == 32'(k + 1));
            line_vec[k] = (32'(i_item.line_number) == 32'(k + 1));
        end
    end

    always_comb begin
        n_pending   = r_pending;
        n_served    = r_served;
        o_read_data = '0;
        case (i_item.req_type)
            icc_pkg::REQ_READ: begin
                if (is_claim) begin
                    n_served = r_served | lowest;
                    if (act != '0) begin
                        o_read_data = icc_pkg::DATA_W'(claim_id);
                    end
                end
            end
            icc_pkg::REQ_WRITE: begin
                if (is_claim) begin
                    n_served = r_served & ~clr_vec;
                end
            end
            icc_pkg::REQ_LINE: begin
                if (i_item.line_level) begin
                    n_pending = r_pending | line_vec;
                end else begin
                    n_pending = r_pending & ~line_vec;
                end
            end
            default: begin
            end
        endcase
        o_ext_irq = ((n_pending & ~n_served) != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_served  <= '0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            r_served  <= n_served;
        end
    end

endmodule

@@ hdl/interrupt_claim_complete_controller.sv @@
// interrupt claim/complete controller, simplified platform interrupt style
//
// input channel (i_in_valid / o_in_ready) carries one item per transfer: a
// register read, a register write or an interrupt line level change. output
// channel (o_out_valid / i_out_ready) returns exactly one item for each input
// item, in order: read_data (claimed source id, else 0) and ext_irq (high
// while any source is pending and not served, after this item's update).
//
// throughput: one item per cycle while the receiver does not stall; an
// accepted item enters the input register, which feeds the mask update
// and priority encoder, whose result lands in the output register.
//
// when the receiver stalls, the output register holds its item and the input
// register holds one more; o_in_ready drops only when both are full.
// reset (i_rst_n low, synchronous) clears the pending and served masks and
// empties both pipeline registers.
module interrupt_claim_complete_controller #(
    parameter int LINE_COUNT     = icc_pkg::LINE_COUNT_DEF,
    parameter int CONTEXT_BASE   = icc_pkg::CONTEXT_BASE_DEF,
    parameter int CONTEXT_STRIDE = icc_pkg::CONTEXT_STRIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [icc_pkg::REQ_W-1:0]    i_req_type,
    input  logic [icc_pkg::OFFSET_W-1:0] i_reg_offset,
    input  logic [icc_pkg::DATA_W-1:0]   i_write_data,
    input  logic [icc_pkg::LINE_W-1:0]   i_line_number,
    input  logic                         i_line_level,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [icc_pkg::DATA_W-1:0]   o_read_data,
    output logic                         o_ext_irq
);

    // stage 1: registered input item
    logic           r_s1_valid;
    icc_pkg::t_item r_s1_item;

    // stage 2: registered result item
    logic                       r_out_valid;
    logic [icc_pkg::DATA_W-1:0] r_read_data;
    logic                       r_ext_irq;

    // engine results for the item in stage 1
    logic [icc_pkg::DATA_W-1:0] n_read_data;
    logic                       n_ext_irq;

    logic out_free;
    logic in_fire;
    logic s1_fire;

    // output slot is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    // stage 1 can take a new item when empty or moving forward
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item.req_type    <= icc_pkg::t_req_type'(i_req_type);
            r_s1_item.reg_offset  <= i_reg_offset;
            r_s1_item.write_data  <= i_write_data;
            r_s1_item.line_number <= i_line_number;
            r_s1_item.line_level  <= i_line_level;
        end
        if (s1_fire) begin
            r_read_data <= n_read_data;
            r_ext_irq   <= n_ext_irq;
        end
    end

    // masks change exactly when the item moves into the output register
    icc_engine #(
        .LINE_COUNT     (LINE_COUNT),
        .CONTEXT_BASE   (CONTEXT_BASE),
        .CONTEXT_STRIDE (CONTEXT_STRIDE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_item      (r_s1_item),
        .o_read_data (n_read_data),
        .o_ext_irq   (n_ext_irq)
    );

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_ext_irq   = r_ext_irq;

endmodule

@@ hdl/icc_checker.sv @@
module icc_checker #(
    parameter int LINE_COUNT = icc_pkg::LINE_COUNT_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [icc_pkg::REQ_W-1:0]    i_req_type,
    input logic [icc_pkg::OFFSET_W-1:0] i_reg_offset,
    input logic [icc_pkg::DATA_W-1:0]   i_write_data,
    input logic [icc_pkg::LINE_W-1:0]   i_line_number,
    input logic                         i_line_level,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [icc_pkg::DATA_W-1:0]   o_read_data,
    input logic                         o_ext_irq
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a waiting input item holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_req_type)
            && $stable(i_reg_offset) && $stable(i_write_data)
            && $stable(i_line_number) && $stable(i_line_level))
        else $error("waiting input item changed");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_ext_irq))
        else $error("stalled result changed");

    // with the output register empty there is always room for an item
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // a claimed id is always a real source number
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_read_data < 32'(LINE_COUNT))
        else $error("claim id out of range");

endmodule

bind interrupt_claim_complete_controller icc_checker #(
    .LINE_COUNT (LINE_COUNT)
) u_icc_checker (.*);
